// ----- hdl/cbrf_pkg.sv -----
// Package for the cubic bisection root finder core.
// Holds the transaction structs, state and code enums and fixed constants.
// No dependencies.
package cbrf_pkg;

  // Reset value of the iteration cap register.
  localparam logic [7:0] CAP_RESET = 8'd100;

  // Constant term of the cubic, 3.0 in Q16.16, at the width of the linear term.
  localparam int unsigned LIN_W = 37;
  localparam logic signed [LIN_W-1:0] CUBIC_CONST = 37'sd196608;

  typedef struct packed {
    logic signed [31:0] left_end;
    logic signed [31:0] right_end;
    logic        [30:0] tolerance;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] root_estimate;
    logic signed [31:0] residual;
    logic        [7:0]  steps_taken;
    logic        [1:0]  stop_reason;
  } out_item_t;

  typedef enum logic [1:0] {
    STOP_TOL  = 2'd0,
    STOP_ZERO = 2'd1,
    STOP_CAP  = 2'd2
  } stop_t;

  // Which point the shared evaluator is working on.
  typedef enum logic [1:0] {
    EV_LEFT  = 2'd0,
    EV_MID   = 2'd1,
    EV_FINAL = 2'd2
  } eval_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQ,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_SAT,
    ST_POST,
    ST_CHECK,
    ST_OUTPUT
  } state_t;

endpackage

// ----- hdl/cubic_bisection_root_finder_core.sv -----
// Top level of the cubic bisection root finder, a single module.
// Depends on cbrf_pkg for types, enums and constants.
//
// Finds a root of p(x) = x^3 - 9x + 3 by bisection in signed Q16.16. One
// transaction is worked on at a time; in_ready is high only while the core is
// idle. The cubic is evaluated on one shared 32x32 multiplier in three passes
// (a*a, low half times a, high half times a) followed by an add and a
// saturating add. The value at the left end is cached, so a step needs only
// the midpoint evaluation. The number of halving steps is bounded by the
// iteration cap (default 100). A finished result sits in the output register
// while the next transaction is accepted. cfg_wr_data sets the cap; write it
// only while idle.
module cubic_bisection_root_finder_core
  import cbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  state_t                  state_r, state_nxt;
  eval_t                   kind_r, kind_nxt;
  stop_t                   reason_r, reason_nxt;
  logic [7:0]              cap_r;
  logic [7:0]              steps_r, steps_nxt;
  logic signed [31:0]      l_r, l_nxt;
  logic signed [31:0]      rt_r, rt_nxt;
  logic [30:0]             tol_r, tol_nxt;
  logic signed [31:0]      x_r, x_nxt;
  logic signed [31:0]      fl_r, fl_nxt;
  logic signed [31:0]      f_r, f_nxt;
  logic                    neg_r, neg_nxt;
  logic [31:0]             a_r, a_nxt;
  logic signed [LIN_W-1:0] k_r, k_nxt;
  logic [63:0]             mult_r, mult_nxt;
  logic [31:0]             hi_r, hi_nxt;
  logic [63:0]             lp_r, lp_nxt;
  logic signed [63:0]      cube_r, cube_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    accept;
  logic                    load_out;
  logic [7:0]              cap_eff;
  logic signed [32:0]      width;
  logic                    width_gt;
  logic signed [32:0]      sum33;
  logic signed [31:0]      mid;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             mul_p;
  logic [63:0]             q;
  logic                    rem;
  logic signed [63:0]      sum64;
  logic signed [LIN_W-1:0] xe;
  logic                    sign_flip;
  logic [7:0]              steps_inc;

  // Handshake and output-register control.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    load_out = (state_r == ST_OUTPUT) && (!out_valid_r || out_ready);
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cap_eff   = (cap_r == 8'd0) ? 8'd1 : cap_r;
  assign width     = $signed({rt_r[31], rt_r}) - $signed({l_r[31], l_r});
  assign width_gt  = width > $signed({2'b00, tol_r});
  assign sum33     = $signed({l_r[31], l_r}) + $signed({rt_r[31], rt_r});
  assign mid       = sum33[32:1];
  assign steps_inc = steps_r + 8'd1;

  // The one shared multiplier.
  always_comb begin
    case (state_r)
      ST_SQ:   begin mul_a = a_r;           mul_b = a_r; end
      ST_LO:   begin mul_a = mult_r[31:0];  mul_b = a_r; end
      ST_HI:   begin mul_a = hi_r;          mul_b = a_r; end
      default: begin mul_a = a_r;           mul_b = a_r; end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // floor(a^3 / 2^32) from the two partial products, then the sign applied.
  assign q   = mult_r + {32'h0, lp_r[63:32]};
  assign rem = |lp_r[31:0];
  assign sum64 = cube_r + {{(64-LIN_W){k_r[LIN_W-1]}}, k_r};
  assign xe  = {{(LIN_W-32){x_r[31]}}, x_r};
  assign sign_flip = (fl_r != 32'sd0) && (fl_r[31] != f_r[31]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_LO;
      ST_LO:     state_nxt = ST_HI;
      ST_HI:     state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_POST;
      ST_POST: begin
        case (kind_r)
          EV_LEFT:  state_nxt = ST_CHECK;
          EV_MID:   state_nxt = (f_r == 32'sd0) ? ST_OUTPUT : ST_CHECK;
          default:  state_nxt = ST_OUTPUT;
        endcase
      end
      ST_CHECK:  state_nxt = ST_PREP;
      ST_OUTPUT: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values.
  always_comb begin
    kind_nxt   = kind_r;
    reason_nxt = reason_r;
    steps_nxt  = steps_r;
    l_nxt      = l_r;
    rt_nxt     = rt_r;
    tol_nxt    = tol_r;
    x_nxt      = x_r;
    fl_nxt     = fl_r;
    f_nxt      = f_r;
    neg_nxt    = neg_r;
    a_nxt      = a_r;
    k_nxt      = k_r;
    mult_nxt   = mult_r;
    hi_nxt     = hi_r;
    lp_nxt     = lp_r;
    cube_nxt   = cube_r;
    out_nxt    = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          l_nxt      = in_data.left_end;
          rt_nxt     = in_data.right_end;
          tol_nxt    = in_data.tolerance;
          x_nxt      = in_data.left_end;
          steps_nxt  = 8'd0;
          reason_nxt = STOP_TOL;
          kind_nxt   = EV_LEFT;
        end
      end
      ST_PREP: begin
        neg_nxt = x_r[31];
        a_nxt   = x_r[31] ? (~x_r + 32'd1) : x_r;
        k_nxt   = CUBIC_CONST - ((xe <<< 3) + xe);
      end
      ST_SQ: begin
        mult_nxt = mul_p;
      end
      ST_LO: begin
        mult_nxt = mul_p;
        hi_nxt   = mult_r[63:32];
      end
      ST_HI: begin
        mult_nxt = mul_p;
        lp_nxt   = mult_r;
      end
      ST_SUM: begin
        // -(q + rem) written as the complement, plus one when exact.
        if (!neg_r) begin
          cube_nxt = q;
        end else if (rem) begin
          cube_nxt = ~q;
        end else begin
          cube_nxt = ~q + 64'd1;
        end
      end
      ST_SAT: begin
        if (!sum64[63] && (|sum64[62:31])) begin
          f_nxt = 32'sh7FFF_FFFF;
        end else if (sum64[63] && !(&sum64[62:31])) begin
          f_nxt = 32'sh8000_0000;
        end else begin
          f_nxt = sum64[31:0];
        end
      end
      ST_POST: begin
        case (kind_r)
          EV_LEFT: fl_nxt = f_r;
          EV_MID: begin
            if (f_r == 32'sd0) begin
              reason_nxt = STOP_ZERO;
            end else begin
              if (sign_flip) begin
                rt_nxt = x_r;
              end else begin
                l_nxt  = x_r;
                fl_nxt = f_r;
              end
              steps_nxt = steps_inc;
              if (steps_inc >= cap_eff) begin
                reason_nxt = STOP_CAP;
              end
            end
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        x_nxt    = mid;
        kind_nxt = (width_gt && (reason_r != STOP_CAP)) ? EV_MID : EV_FINAL;
      end
      ST_OUTPUT: begin
        if (load_out) begin
          out_nxt.root_estimate = x_r;
          out_nxt.residual      = f_r;
          out_nxt.steps_taken   = steps_r;
          out_nxt.stop_reason   = reason_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    reason_r <= reason_nxt;
    steps_r  <= steps_nxt;
    l_r      <= l_nxt;
    rt_r     <= rt_nxt;
    tol_r    <= tol_nxt;
    x_r      <= x_nxt;
    fl_r     <= fl_nxt;
    f_r      <= f_nxt;
    neg_r    <= neg_nxt;
    a_r      <= a_nxt;
    k_r      <= k_nxt;
    mult_r   <= mult_nxt;
    hi_r     <= hi_nxt;
    lp_r     <= lp_nxt;
    cube_r   <= cube_nxt;
    out_r    <= out_nxt;
  end

`ifndef SYNTHESIS
  // An accepted transaction always starts with the left-end evaluation.
  a_accept_starts_left: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_PREP) && (kind_r == EV_LEFT))
    else $error("accepted transaction did not start the left-end evaluation");

  // The multiplier passes run in order.
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HI) |-> ($past(state_r) == ST_LO))
    else $error("high partial product without the low pass before it");

  // An exact-zero stop reports a zero residual.
  a_zero_residual: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.stop_reason == STOP_ZERO)) |-> (out_r.residual == 32'sd0))
    else $error("exact-zero stop with nonzero residual");

  // A cap stop means at least one halving step was taken.
  a_cap_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.stop_reason == STOP_CAP)) |-> (out_r.steps_taken != 8'd0))
    else $error("cap stop reported with no steps");

  // A result loads only when the output register is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("pending result overwritten");
`endif

endmodule

// ----- bench/cubic_bisection_root_finder_core_test.sv -----
// Self-checking testbench for cubic_bisection_root_finder_core.
// Depends on cbrf_pkg and the core; predicts every result from the interval and the cap,
// then checks each output transaction field by field under random gaps and stalls.
module cubic_bisection_root_finder_core_test
  import cbrf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_ONE = 64'sd65536;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int unsigned PRESSURE_AFTER = 150;
  localparam int unsigned PRESSURE_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  in_item_t    feed_q[$];
  out_item_t   root_expect_q[$];
  longint      zero_pts[$];

  logic [7:0]  iter_cap = CAP_RESET;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned feed_gap = 0;
  int unsigned drain_gap = 0;
  int unsigned hold_left = 0;
  int unsigned items_issued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cap_settings = 1;
  int unsigned stop_tally[3] = '{0, 0, 0};

  cubic_bisection_root_finder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // p(x) = x^3 - 9x + 3 on a raw Q16.16 value, floored, then saturated to 32 bits.
  function automatic longint cubic_value(longint x);
    logic signed [95:0] xw;
    logic signed [95:0] c3;
    logic signed [95:0] r;
    xw = x;
    c3 = xw * xw * xw;
    r = (c3 >>> 32) - 96'sd9 * xw + CUBIC_CONST;
    if (r > 96'sd2147483647) return Q_MAX;
    if (r < -96'sd2147483648) return Q_MIN;
    return longint'(r);
  endfunction

  function automatic out_item_t solve_bisection(in_item_t it, logic [7:0] cap_reg);
    longint      lo;
    longint      hi;
    longint      tol;
    longint      mid;
    longint      f_mid;
    longint      f_lo;
    int unsigned limit;
    int unsigned steps;
    bit          done;
    stop_t       why;
    out_item_t   res;
    lo = it.left_end;
    hi = it.right_end;
    tol = it.tolerance;
    limit = (cap_reg == 0) ? 1 : cap_reg;
    steps = 0;
    done = 1'b0;
    why = STOP_TOL;
    while (!done && (hi - lo > tol)) begin
      mid = (lo + hi) >>> 1;
      f_mid = cubic_value(mid);
      if (f_mid == 0) begin
        why = STOP_ZERO;
        done = 1'b1;
      end else begin
        f_lo = cubic_value(lo);
        if (f_lo != 0 && ((f_lo < 0) != (f_mid < 0))) hi = mid;
        else lo = mid;
        steps++;
        if (steps >= limit) begin
          why = STOP_CAP;
          done = 1'b1;
        end
      end
    end
    mid = (lo + hi) >>> 1;
    f_mid = cubic_value(mid);
    res.root_estimate = mid[31:0];
    res.residual = f_mid[31:0];
    res.steps_taken = 8'(steps);
    res.stop_reason = why;
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic in_item_t make_item(longint lo, longint hi, longint tol);
    in_item_t it;
    longint   l;
    longint   r;
    l = clamp32(lo);
    r = clamp32(hi);
    it.left_end = l[31:0];
    it.right_end = r[31:0];
    it.tolerance = tol[30:0];
    return it;
  endfunction

  // Rough raw positions of the three real roots.
  function automatic longint root_guess(int idx);
    case (idx)
      0:       return -64'sd206733;
      1:       return 64'sd22126;
      default: return 64'sd184608;
    endcase
  endfunction

  // Either a root neighborhood or a point where the cubic is exactly zero.
  function automatic longint pick_root();
    int unsigned k;
    k = $urandom_range(0, 2 + zero_pts.size());
    if (k < 3) return root_guess(k) + longint'($urandom_range(0, 400)) - 200;
    return zero_pts[k - 3];
  endfunction

  function automatic longint pick_tol();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 4) return longint'($urandom_range(0, 255));
    return longint'($urandom >> $urandom_range(1, 31));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic in_item_t make_random_item();
    longint      lo;
    longint      hi;
    longint      centre;
    int          sa;
    int          sb;
    int unsigned kind;
    int unsigned span;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // Bracket around a root at a random scale.
      centre = pick_root();
      span = $urandom_range(0, 30);
      lo = centre - longint'($urandom_range(0, 32'd1 << span));
      hi = centre + longint'($urandom_range(1, 32'd1 << span));
      return make_item(lo, hi, pick_tol());
    end
    if (kind < 70) begin
      centre = pick_root();
      lo = centre - longint'($urandom_range(0, 64));
      hi = centre + longint'($urandom_range(0, 64));
      return make_item(lo, hi, longint'($urandom_range(0, 4)));
    end
    sa = $urandom;
    sb = $urandom;
    if (kind < 85) return make_item(sa, sb, pick_tol());
    if (kind < 95) begin
      if (sa > sb) return make_item(sb, sa, pick_tol());
      return make_item(sa, sb, pick_tol());
    end
    if (kind[0]) return make_item(sa, sa, pick_tol());
    return make_item(sa, longint'(sa) - longint'($urandom_range(1, 1000)), pick_tol());
  endfunction

  function automatic void queue_item(in_item_t it);
    feed_q.push_back(it);
    items_issued++;
  endfunction

  function automatic void queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_item(make_random_item());
  endfunction

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100) $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // Sender: presents queued transactions with random gaps between them.
  always @(posedge clk) begin
    out_item_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pred = solve_bisection(in_data, iter_cap);
        root_expect_q.push_back(pred);
        stop_tally[pred.stop_reason]++;
      end
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= feed_q.pop_front();
          feed_gap = steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off so the core backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= PRESSURE_AFTER) begin
      hold_done = 1'b1;
      hold_left = PRESSURE_CYCLES;
      out_ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 2) == 0) drain_gap = pick_gap();
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (root_expect_q.size() == 0) begin
        mismatches++;
        $error("result transaction with none outstanding: root_estimate %0d",
               out_data.root_estimate);
      end else begin
        want = root_expect_q.pop_front();
        check_field("root_estimate", want.root_estimate, out_data.root_estimate);
        check_field("residual", want.residual, out_data.residual);
        check_field("steps_taken", want.steps_taken, out_data.steps_taken);
        check_field("stop_reason", want.stop_reason, out_data.stop_reason);
      end
    end
  end

  task automatic wait_idle();
    while (results_seen < items_issued) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic new_phase(logic [7:0] cap, bit no_gaps);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    iter_cap = cap;
    steady = no_gaps;
    cap_settings++;
  endtask

  initial begin
    longint z;
    for (int g = 0; g < 3; g++) begin
      for (longint x = root_guess(g) - 2500; x <= root_guess(g) + 2500; x++) begin
        if (cubic_value(x) == 0) zero_pts.push_back(x);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Cap at its reset value: extremes, empty and reversed intervals, exact zeros.
    queue_item(make_item(0, Q_ONE, 1));
    queue_item(make_item(0, Q_ONE, 0));
    queue_item(make_item(2 * Q_ONE, 3 * Q_ONE, 64'h40));
    queue_item(make_item(-4 * Q_ONE, -3 * Q_ONE, 64'h100));
    queue_item(make_item(Q_ONE, 0, 0));
    queue_item(make_item(5 * Q_ONE, 5 * Q_ONE, 0));
    queue_item(make_item(0, Q_ONE, Q_ONE));
    queue_item(make_item(0, Q_ONE, Q_ONE - 1));
    queue_item(make_item(Q_MIN, Q_MAX, 0));
    queue_item(make_item(Q_MIN, Q_MAX, Q_MAX));
    queue_item(make_item(Q_MAX, Q_MAX, Q_MAX));
    queue_item(make_item(Q_MIN, Q_MIN, 0));
    queue_item(make_item(Q_MAX, Q_MIN, 0));
    queue_item(make_item(-1, 0, 0));
    queue_item(make_item(Q_MAX - Q_ONE + 1, Q_MAX, 0));
    queue_item(make_item(Q_MIN, Q_MIN + Q_ONE, 0));
    queue_item(make_item(-10 * Q_ONE, 10 * Q_ONE, 64'h20));
    if (zero_pts.size() > 0) begin
      z = zero_pts[0];
      queue_item(make_item(z - 64'h800, z + 64'h800, 0));
      queue_item(make_item(z, z + Q_ONE, 0));
      queue_item(make_item(z - 1, z + 1, 1));
    end
    queue_random(300);

    // A single step allowed; the cap wins when the tolerance is met on the same step.
    new_phase(8'd1, 1'b0);
    queue_item(make_item(0, 2 * Q_ONE, Q_ONE));
    queue_item(make_item(0, Q_ONE, 0));
    queue_random(250);

    new_phase(8'd255, 1'b0);
    queue_random(100);

    // A zero cap behaves as a cap of one.
    new_phase(8'd0, 1'b0);
    queue_item(make_item(0, 2 * Q_ONE, Q_ONE));
    queue_random(200);

    new_phase(8'd13, 1'b1);
    queue_random(300);

    new_phase(8'd64, 1'b0);
    queue_random(250);

    new_phase(8'd200, 1'b0);
    queue_random(100);

    new_phase(CAP_RESET, 1'b0);
    queue_random(200);

    while (results_seen < items_issued) @(posedge clk);
    repeat (100) @(posedge clk);
    if (root_expect_q.size() != 0) begin
      mismatches++;
      $error("%0d expected results never arrived", root_expect_q.size());
    end

    $display("Checked %0d result transactions over %0d iteration cap settings.",
             results_seen, cap_settings);
    $display("Stops by tolerance %0d, exact zero %0d, cap %0d; %0d exact-zero points known.",
             stop_tally[STOP_TOL], stop_tally[STOP_ZERO], stop_tally[STOP_CAP],
             zero_pts.size());
    if (mismatches == 0) begin
      $display("cubic_bisection_root_finder_core_test passed");
    end else begin
      $display("cubic_bisection_root_finder_core_test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #150_000_000;
    $display("cubic_bisection_root_finder_core_test failed");
    $finish;
  end

endmodule
